/* sv/oledfb_pkg.sv */
package oledfb_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PIXEL   = 2'd0;
  localparam kind_t KIND_FILL    = 2'd1;
  localparam kind_t KIND_CLEAR   = 2'd2;
  localparam kind_t KIND_REFRESH = 2'd3;

  localparam logic CFG_INVERT = 1'b0;
  localparam logic CFG_TALL   = 1'b1;

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] LOW_COL_CMD   = 8'h00;
  localparam logic [7:0] HIGH_COL_CMD  = 8'h10;
  localparam logic [7:0] ALL_ON        = 8'hFF;
  localparam int         HEADER_LEN    = 3;

  typedef struct packed {
    logic       go;
    logic [7:0] fill;
  } sweep_req_t;

endpackage

/* sv/oledfb_ram.sv */
module oledfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/oledfb_sweep.sv */
module oledfb_sweep #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  oledfb_pkg::sweep_req_t   req_i,
  output logic                     active_o,
  output logic [$clog2(DEPTH)-1:0] addr_o,
  output logic [7:0]               data_o
);
  import oledfb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [7:0]    fill_q, fill_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.go) begin
          state_d = ST_RUN;
          cnt_d   = '0;
          fill_d  = req_i.fill;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // reset starts a zero pass over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
    end
  end

  assign active_o = (state_q == ST_RUN);
  assign addr_o   = cnt_q;
  assign data_o   = fill_q;

endmodule

/* sv/oled_page_framebuffer_refresh.sv */
// Page-organized monochrome framebuffer with a byte-serial panel refresh stream.
// Commands enter on start/kind_i/x_i/y_i/color_i and are taken at a clock edge
// with start high and busy low. Each command gives one result word on the
// cycle after it is taken, flagged by done_o for exactly one cycle; the
// receiver has no way to stall, so every word must be captured when shown.
// Pixel writes and refresh steps may follow back to back: the store is a
// single memory with one read and one write port, a pixel write reads in its
// accept cycle and writes back in the next one, with forwarding when the
// following command touches the same byte.
// Fill and clear sweep the store one byte per cycle over all
// PANEL_WIDTH * MAX_ROWS / 8 bytes (1024 by default), and busy stays high
// while the sweep runs. After reset the same sweep zeros the store, so busy
// is high until it ends, before the first command can be taken.
// Configuration words (invert, tall panel) go on cfg_valid_i/cfg_index_i/
// cfg_data_i, always ready, and must only be written while no command is in
// flight. The refresh pointer moves only on refresh steps.
module oled_page_framebuffer_refresh #(
  parameter int PANEL_WIDTH = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  oledfb_pkg::kind_t kind_i,
  input  logic [6:0]        x_i,
  input  logic [5:0]        y_i,
  input  logic              color_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic              cfg_data_i,
  output logic              done_o,
  output logic              status_o,
  output logic              has_byte_o,
  output logic [7:0]        out_byte_o,
  output logic              is_command_o,
  output logic              frame_end_o
);
  import oledfb_pkg::*;

  localparam int MAX_PAGES = MAX_ROWS / 8;
  localparam int DEPTH     = PANEL_WIDTH * MAX_PAGES;
  localparam int AW        = $clog2(DEPTH);
  localparam logic [3:0]    PAGES_TALL  = (MAX_PAGES < 8) ? 4'(MAX_PAGES) : 4'd8;
  localparam logic [3:0]    PAGES_SHORT = (MAX_PAGES < 4) ? 4'(MAX_PAGES) : 4'd4;
  localparam logic [AW-1:0] PW_A     = AW'(PANEL_WIDTH);
  localparam logic [7:0]    PW_X     = 8'(PANEL_WIDTH);
  localparam logic [7:0]    HDR      = 8'(HEADER_LEN);
  localparam logic [7:0]    LINE_LEN = 8'(HEADER_LEN + PANEL_WIDTH);
  localparam logic [7:0]    LAST_POS = 8'(HEADER_LEN + PANEL_WIDTH - 1);

  logic accept;
  logic invert_q, tall_q;
  logic [2:0] page_q, page_d;
  logic [7:0] pos_q, pos_d;

  logic [3:0]    pages;
  logic          bitv, pix_ok, restart;
  logic [AW-1:0] pix_addr, ref_addr, raddr;
  logic [2:0]    eff_page;
  logic [7:0]    eff_pos, col, pos_inc, cmd_byte;
  logic [3:0]    page_inc;
  logic          is_cmd_nx, fend_nx;

  logic          res_q, pix_q, status_q, hasb_q, cmd_q, fend_q;
  logic [7:0]    cbyte_q, mask_q;
  logic [AW-1:0] addr_q;
  logic          bit_q;

  logic          fwd_q;
  logic [AW-1:0] fwd_addr_q;
  logic [7:0]    fwd_data_q;

  logic [7:0]    ram_rdata, rd_data, pix_wdata, ram_wdata;
  logic          pix_we, ram_we, ram_re;
  logic [AW-1:0] ram_waddr;

  sweep_req_t    sweep_req;
  logic          sweep_active;
  logic [AW-1:0] sweep_addr;
  logic [7:0]    sweep_data;

  assign accept      = start && !busy;
  assign busy        = sweep_active;
  assign cfg_ready_o = 1'b1;

  // command decode
  always_comb begin
    pages    = tall_q ? PAGES_TALL : PAGES_SHORT;
    bitv     = color_i ^ invert_q;
    pix_ok   = ({1'b0, x_i} < PW_X) && ({1'b0, y_i} < {pages, 3'b000});
    pix_addr = AW'(y_i[5:3]) * PW_A + AW'(x_i);

    restart  = ({1'b0, page_q} >= pages) || (pos_q >= LINE_LEN);
    eff_page = restart ? 3'd0 : page_q;
    eff_pos  = restart ? 8'd0 : pos_q;
    col      = eff_pos - HDR;
    ref_addr = AW'(eff_page) * PW_A + AW'(col);
    pos_inc  = eff_pos + 8'd1;
    page_inc = {1'b0, eff_page} + 4'd1;

    if (pos_inc >= LINE_LEN) begin
      pos_d  = 8'd0;
      page_d = (page_inc >= pages) ? 3'd0 : page_inc[2:0];
    end else begin
      pos_d  = pos_inc;
      page_d = eff_page;
    end

    case (eff_pos)
      8'd0:    cmd_byte = PAGE_CMD_BASE + {5'b0, eff_page};
      8'd1:    cmd_byte = LOW_COL_CMD;
      8'd2:    cmd_byte = HIGH_COL_CMD;
      default: cmd_byte = 8'h00;
    endcase
    is_cmd_nx = (eff_pos < HDR);
    fend_nx   = (page_inc == pages) && (eff_pos == LAST_POS);

    ram_re = accept && ((kind_i == KIND_PIXEL) || (kind_i == KIND_REFRESH));
    raddr  = (kind_i == KIND_PIXEL) ? pix_addr : ref_addr;

    sweep_req.go   = accept && ((kind_i == KIND_FILL) || (kind_i == KIND_CLEAR));
    sweep_req.fill = ((kind_i == KIND_FILL) && bitv) ? ALL_ON : 8'h00;
  end

  // configuration and refresh pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      tall_q   <= 1'b1;
      page_q   <= 3'd0;
      pos_q    <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_INVERT: invert_q <= cfg_data_i;
          CFG_TALL:   tall_q   <= cfg_data_i;
          default:    tall_q   <= tall_q;
        endcase
      end
      if (accept && (kind_i == KIND_REFRESH)) begin
        page_q <= page_d;
        pos_q  <= pos_d;
      end
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q    <= 1'b0;
      pix_q    <= 1'b0;
      status_q <= 1'b0;
      hasb_q   <= 1'b0;
      cmd_q    <= 1'b0;
      fend_q   <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      res_q    <= accept;
      pix_q    <= accept && (kind_i == KIND_PIXEL) && pix_ok;
      status_q <= accept && (kind_i == KIND_PIXEL) && !pix_ok;
      hasb_q   <= accept && (kind_i == KIND_REFRESH);
      cmd_q    <= accept && (kind_i == KIND_REFRESH) && is_cmd_nx;
      fend_q   <= accept && (kind_i == KIND_REFRESH) && fend_nx;
      fwd_q    <= pix_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= raddr;
      mask_q  <= 8'd1 << y_i[2:0];
      bit_q   <= bitv;
      cbyte_q <= cmd_byte;
    end
    fwd_addr_q <= addr_q;
    fwd_data_q <= pix_wdata;
  end

  // read-modify-write with forwarding of the previous write-back
  always_comb begin
    rd_data   = (fwd_q && (fwd_addr_q == addr_q)) ? fwd_data_q : ram_rdata;
    pix_wdata = bit_q ? (rd_data | mask_q) : (rd_data & ~mask_q);
    pix_we    = res_q && pix_q;
    ram_we    = sweep_active || pix_we;
    ram_waddr = sweep_active ? sweep_addr : addr_q;
    ram_wdata = sweep_active ? sweep_data : pix_wdata;
  end

  oledfb_sweep #(
    .DEPTH(DEPTH)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sweep_req),
    .active_o(sweep_active),
    .addr_o  (sweep_addr),
    .data_o  (sweep_data)
  );

  oledfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign done_o       = res_q;
  assign status_o     = status_q;
  assign has_byte_o   = hasb_q;
  assign is_command_o = cmd_q;
  assign frame_end_o  = fend_q;
  assign out_byte_o   = hasb_q ? (cmd_q ? cbyte_q : rd_data) : 8'h00;

endmodule

/* sv/oledfb_checker.sv */
module oledfb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input oledfb_pkg::kind_t kind_i,
  input logic [6:0]        x_i,
  input logic [5:0]        y_i,
  input logic              color_i,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              cfg_index_i,
  input logic              cfg_data_i,
  input logic              done_o,
  input logic              status_o,
  input logic              has_byte_o,
  input logic [7:0]        out_byte_o,
  input logic              is_command_o,
  input logic              frame_end_o
);
  import oledfb_pkg::*;

  // one word the cycle after each accepted command, none otherwise
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (done_o == $past(start && !busy)))
    else $error("result word does not follow accepted command");

  // fill and clear hold off new commands while the store is swept
  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((kind_i == KIND_FILL) || (kind_i == KIND_CLEAR))) |=> busy)
    else $error("busy not raised for store sweep");

  // busy only rises after a fill or clear
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && ((kind_i == KIND_FILL) || (kind_i == KIND_CLEAR))))
    else $error("busy raised without a sweep command");

  // refresh words only for refresh steps, status only for pixel writes
  a_refresh_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (has_byte_o || status_o)) |->
      (has_byte_o ? ($past(kind_i) == KIND_REFRESH) : ($past(kind_i) == KIND_PIXEL)))
    else $error("result fields do not match command kind");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && frame_end_o) |-> (has_byte_o && !is_command_o && !status_o))
    else $error("frame end on a non-data word");

endmodule

bind oled_page_framebuffer_refresh oledfb_checker u_oledfb_checker (.*);
